// ===== rtl/core/sis_pkg.sv =====
// Shared constants for the segment intersection block.
package sis_pkg;
	localparam int COORD_WIDTH = 32;
endpackage

// ===== rtl/core/sis_front.sv =====
// Front pipeline: deltas, cross products, sign normalization and range test.
module sis_front #(
	parameter int COORD_WIDTH = sis_pkg::COORD_WIDTH,
	localparam int W  = COORD_WIDTH,
	localparam int DW = COORD_WIDTH + 1,
	localparam int CW = 2 * COORD_WIDTH + 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [W-1:0]  a_start_x,
	input  logic signed [W-1:0]  a_start_y,
	input  logic signed [W-1:0]  a_end_x,
	input  logic signed [W-1:0]  a_end_y,
	input  logic signed [W-1:0]  b_start_x,
	input  logic signed [W-1:0]  b_start_y,
	input  logic signed [W-1:0]  b_end_x,
	input  logic signed [W-1:0]  b_end_y,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 hit,
	output logic [CW-1:0]        den,
	output logic [CW-1:0]        num,
	output logic [W-1:0]         mag_x,
	output logic [W-1:0]         mag_y,
	output logic                 neg_x,
	output logic                 neg_y,
	output logic [W-1:0]         p1_x,
	output logic [W-1:0]         p1_y
);
	logic [5:1] v_q;
	logic [6:1] en;

	logic signed [DW-1:0] dax_s1, day_s1, dbx_s1, dby_s1, ex_s1, ey_s1;
	logic [W-1:0] p1x_s1, p1y_s1;
	logic signed [CW-1:0] m0_s2, m1_s2, m2_s2, m3_s2, m4_s2, m5_s2;
	logic signed [DW-1:0] dax_s2, day_s2, dax_s3, day_s3;
	logic [W-1:0] p1x_s2, p1y_s2, p1x_s3, p1y_s3, p1x_s4, p1y_s4, p1x_s5, p1y_s5;
	logic signed [CW-1:0] d_s3, nu_s3, nv_s3, d_s4, nu_s4, nv_s4;
	logic dz_s4, hit_s5, nx_s4, ny_s4, nx_s5, ny_s5;
	logic [W-1:0] mx_s4, my_s4, mx_s5, my_s5;
	logic [CW-1:0] d_s5, nu_s5;
	logic signed [DW-1:0] abs_x, abs_y;

	always_comb begin
		en[6] = out_ready;
		for (int k = 5; k >= 1; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end
	assign in_ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[1]) v_q[1] <= in_valid;
			for (int k = 2; k <= 5; k++) begin
				if (en[k]) v_q[k] <= v_q[k-1];
			end
		end
	end

	assign abs_x = dax_s3[DW-1] ? -dax_s3 : dax_s3;
	assign abs_y = day_s3[DW-1] ? -day_s3 : day_s3;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			dax_s1 <= DW'(a_end_x) - DW'(a_start_x);
			day_s1 <= DW'(a_end_y) - DW'(a_start_y);
			dbx_s1 <= DW'(b_end_x) - DW'(b_start_x);
			dby_s1 <= DW'(b_end_y) - DW'(b_start_y);
			ex_s1  <= DW'(b_start_x) - DW'(a_start_x);
			ey_s1  <= DW'(b_start_y) - DW'(a_start_y);
			p1x_s1 <= a_start_x;
			p1y_s1 <= a_start_y;
		end
		if (en[2]) begin
			m0_s2  <= CW'(dax_s1 * dby_s1);
			m1_s2  <= CW'(day_s1 * dbx_s1);
			m2_s2  <= CW'(ex_s1 * dby_s1);
			m3_s2  <= CW'(ey_s1 * dbx_s1);
			m4_s2  <= CW'(ex_s1 * day_s1);
			m5_s2  <= CW'(ey_s1 * dax_s1);
			dax_s2 <= dax_s1;
			day_s2 <= day_s1;
			p1x_s2 <= p1x_s1;
			p1y_s2 <= p1y_s1;
		end
		if (en[3]) begin
			d_s3   <= m0_s2 - m1_s2;
			nu_s3  <= m2_s2 - m3_s2;
			nv_s3  <= m4_s2 - m5_s2;
			dax_s3 <= dax_s2;
			day_s3 <= day_s2;
			p1x_s3 <= p1x_s2;
			p1y_s3 <= p1y_s2;
		end
		if (en[4]) begin
			d_s4   <= d_s3[CW-1] ? -d_s3 : d_s3;
			nu_s4  <= d_s3[CW-1] ? -nu_s3 : nu_s3;
			nv_s4  <= d_s3[CW-1] ? -nv_s3 : nv_s3;
			dz_s4  <= (d_s3 == '0);
			mx_s4  <= W'(abs_x);
			my_s4  <= W'(abs_y);
			nx_s4  <= dax_s3[DW-1];
			ny_s4  <= day_s3[DW-1];
			p1x_s4 <= p1x_s3;
			p1y_s4 <= p1y_s3;
		end
		if (en[5]) begin
			hit_s5 <= !dz_s4 && !nu_s4[CW-1] && (nu_s4 <= d_s4)
				&& !nv_s4[CW-1] && (nv_s4 <= d_s4);
			d_s5   <= d_s4;
			nu_s5  <= nu_s4;
			mx_s5  <= mx_s4;
			my_s5  <= my_s4;
			nx_s5  <= nx_s4;
			ny_s5  <= ny_s4;
			p1x_s5 <= p1x_s4;
			p1y_s5 <= p1y_s4;
		end
	end

	assign out_valid = v_q[5];
	assign hit   = hit_s5;
	assign den   = d_s5;
	assign num   = nu_s5;
	assign mag_x = mx_s5;
	assign mag_y = my_s5;
	assign neg_x = nx_s5;
	assign neg_y = ny_s5;
	assign p1_x  = p1x_s5;
	assign p1_y  = p1y_s5;
endmodule

// ===== rtl/core/sis_div_cell.sv =====
// One cell of the scaled division chain: one multiplier bit, one quotient digit per lane.
module sis_div_cell #(
	parameter int COORD_WIDTH = sis_pkg::COORD_WIDTH,
	localparam int W  = COORD_WIDTH,
	localparam int CW = 2 * COORD_WIDTH + 2,
	localparam int RW = 2 * COORD_WIDTH + 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  logic          hit_i,
	input  logic [CW-1:0] den_i,
	input  logic [CW-1:0] num_i,
	input  logic [W-1:0]  mx_i,
	input  logic [W-1:0]  my_i,
	input  logic [RW-1:0] rx_i,
	input  logic [RW-1:0] ry_i,
	input  logic [W-1:0]  qx_i,
	input  logic [W-1:0]  qy_i,
	input  logic          nx_i,
	input  logic          ny_i,
	input  logic [W-1:0]  p1x_i,
	input  logic [W-1:0]  p1y_i,
	output logic          hit_o,
	output logic [CW-1:0] den_o,
	output logic [CW-1:0] num_o,
	output logic [W-1:0]  mx_o,
	output logic [W-1:0]  my_o,
	output logic [RW-1:0] rx_o,
	output logic [RW-1:0] ry_o,
	output logic [W-1:0]  qx_o,
	output logic [W-1:0]  qy_o,
	output logic          nx_o,
	output logic          ny_o,
	output logic [W-1:0]  p1x_o,
	output logic [W-1:0]  p1y_o
);
	logic v_q;
	logic [RW-1:0] d1, d2, tx, ty, rxn, ryn;
	logic [W-1:0] qxn, qyn;

	assign in_ready = !v_q || out_ready;
	assign d1 = RW'(den_i);
	assign d2 = {d1[RW-2:0], 1'b0};
	assign tx = {rx_i[RW-2:0], 1'b0} + (mx_i[W-1] ? RW'(num_i) : '0);
	assign ty = {ry_i[RW-2:0], 1'b0} + (my_i[W-1] ? RW'(num_i) : '0);

	always_comb begin
		if (tx >= d2) begin
			rxn = tx - d2;
			qxn = {qx_i[W-2:0], 1'b0} + W'(2);
		end else if (tx >= d1) begin
			rxn = tx - d1;
			qxn = {qx_i[W-2:0], 1'b0} + W'(1);
		end else begin
			rxn = tx;
			qxn = {qx_i[W-2:0], 1'b0};
		end
		if (ty >= d2) begin
			ryn = ty - d2;
			qyn = {qy_i[W-2:0], 1'b0} + W'(2);
		end else if (ty >= d1) begin
			ryn = ty - d1;
			qyn = {qy_i[W-2:0], 1'b0} + W'(1);
		end else begin
			ryn = ty;
			qyn = {qy_i[W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			hit_o <= hit_i;
			den_o <= den_i;
			num_o <= num_i;
			mx_o  <= {mx_i[W-2:0], 1'b0};
			my_o  <= {my_i[W-2:0], 1'b0};
			rx_o  <= rxn;
			ry_o  <= ryn;
			qx_o  <= qxn;
			qy_o  <= qyn;
			nx_o  <= nx_i;
			ny_o  <= ny_i;
			p1x_o <= p1x_i;
			p1y_o <= p1y_i;
		end
	end

	assign out_valid = v_q;
endmodule

// ===== rtl/core/segment_intersection_top.sv =====
// Top level of the fixed-point segment intersection pipeline.
// Usage:
//   Input channel (in_valid / in_stall) carries segment A (a_start, a_end) and
//   segment B (b_start, b_end) as signed fixed-point coordinates. A transaction
//   is taken on a rising edge with in_valid high and in_stall low.
//   Output channel (out_valid / out_stall) returns hit and the crossing point;
//   the point is zero when hit is low.
// Pipeline: five front stages, one division cell per magnitude bit, one output
//   register.
// Throughput: one transaction per cycle; every stage is a register with its
//   own valid, so the front, the division chain and the output register all
//   advance every cycle while the receiver takes results.
// Stall: when out_stall holds a result, stages fill up behind it and
//   in_stall rises only once the pipeline has no empty stage left.
// Reset: arst_n clears all valid bits; the pipeline comes up empty.
module segment_intersection_top #(
	parameter int COORD_WIDTH = sis_pkg::COORD_WIDTH,
	localparam int W  = COORD_WIDTH,
	localparam int CW = 2 * COORD_WIDTH + 2,
	localparam int RW = 2 * COORD_WIDTH + 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [W-1:0] a_start_x,
	input  logic signed [W-1:0] a_start_y,
	input  logic signed [W-1:0] a_end_x,
	input  logic signed [W-1:0] a_end_y,
	input  logic signed [W-1:0] b_start_x,
	input  logic signed [W-1:0] b_start_y,
	input  logic signed [W-1:0] b_end_x,
	input  logic signed [W-1:0] b_end_y,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                hit,
	output logic signed [W-1:0] point_x,
	output logic signed [W-1:0] point_y
);
	logic [W:0] cv, crdy;
	logic [W:0] chit, cnx, cny;
	logic [CW-1:0] cden [W+1];
	logic [CW-1:0] cnum [W+1];
	logic [W-1:0] cmx [W+1];
	logic [W-1:0] cmy [W+1];
	logic [RW-1:0] crx [W+1];
	logic [RW-1:0] cry [W+1];
	logic [W-1:0] cqx [W+1];
	logic [W-1:0] cqy [W+1];
	logic [W-1:0] cpx [W+1];
	logic [W-1:0] cpy [W+1];
	logic fr_ready, ov_q, o_en;
	logic hit_q;
	logic [W-1:0] px_q, py_q, ox, oy;

	sis_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(fr_ready),
		.a_start_x(a_start_x), .a_start_y(a_start_y),
		.a_end_x(a_end_x), .a_end_y(a_end_y),
		.b_start_x(b_start_x), .b_start_y(b_start_y),
		.b_end_x(b_end_x), .b_end_y(b_end_y),
		.out_valid(cv[0]), .out_ready(crdy[0]),
		.hit(chit[0]), .den(cden[0]), .num(cnum[0]),
		.mag_x(cmx[0]), .mag_y(cmy[0]), .neg_x(cnx[0]), .neg_y(cny[0]),
		.p1_x(cpx[0]), .p1_y(cpy[0])
	);
	assign in_stall = !fr_ready;
	assign crx[0] = '0;
	assign cry[0] = '0;
	assign cqx[0] = '0;
	assign cqy[0] = '0;

	for (genvar k = 0; k < W; k++) begin : g_cell
		sis_div_cell #(.COORD_WIDTH(COORD_WIDTH)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.in_valid(cv[k]), .in_ready(crdy[k]),
			.out_valid(cv[k+1]), .out_ready(crdy[k+1]),
			.hit_i(chit[k]), .den_i(cden[k]), .num_i(cnum[k]),
			.mx_i(cmx[k]), .my_i(cmy[k]), .rx_i(crx[k]), .ry_i(cry[k]),
			.qx_i(cqx[k]), .qy_i(cqy[k]), .nx_i(cnx[k]), .ny_i(cny[k]),
			.p1x_i(cpx[k]), .p1y_i(cpy[k]),
			.hit_o(chit[k+1]), .den_o(cden[k+1]), .num_o(cnum[k+1]),
			.mx_o(cmx[k+1]), .my_o(cmy[k+1]), .rx_o(crx[k+1]), .ry_o(cry[k+1]),
			.qx_o(cqx[k+1]), .qy_o(cqy[k+1]), .nx_o(cnx[k+1]), .ny_o(cny[k+1]),
			.p1x_o(cpx[k+1]), .p1y_o(cpy[k+1])
		);
	end

	assign o_en = !ov_q || !out_stall;
	assign crdy[W] = o_en;
	assign ox = cpx[W] + (cnx[W] ? -cqx[W] : cqx[W]);
	assign oy = cpy[W] + (cny[W] ? -cqy[W] : cqy[W]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (o_en) begin
			ov_q <= cv[W];
		end
	end

	always_ff @(posedge clk) begin
		if (o_en) begin
			hit_q <= chit[W];
			px_q  <= chit[W] ? ox : '0;
			py_q  <= chit[W] ? oy : '0;
		end
	end

	assign out_valid = ov_q;
	assign hit     = hit_q;
	assign point_x = px_q;
	assign point_y = py_q;
endmodule

// ===== verif/segment_intersection_top_tb.sv =====
// Testbench for segment_intersection_top: random and directed segment pairs checked against a predictor.
`timescale 1ns / 1ps

module segment_intersection_top_tb;

	localparam int W = sis_pkg::COORD_WIDTH;
	localparam int LATENCY = W + 6;
	localparam int N_RANDOM = 1450;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct {
		logic signed [W-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
	} seg_pair_t;

	typedef struct {
		logic                hit;
		logic signed [W-1:0] px, py;
	} crossing_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [W-1:0] a_start_x = '0, a_start_y = '0, a_end_x = '0, a_end_y = '0;
	logic signed [W-1:0] b_start_x = '0, b_start_y = '0, b_end_x = '0, b_end_y = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic hit;
	logic signed [W-1:0] point_x, point_y;

	seg_pair_t pending_pairs[$];
	crossing_t expected_crossings[$];
	int mismatches = 0;
	bit stimulus_done = 1'b0;
	longint cycle_count = 0;

	segment_intersection_top u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.a_start_x(a_start_x), .a_start_y(a_start_y),
		.a_end_x(a_end_x), .a_end_y(a_end_y),
		.b_start_x(b_start_x), .b_start_y(b_start_y),
		.b_end_x(b_end_x), .b_end_y(b_end_y),
		.out_valid(out_valid), .out_stall(out_stall),
		.hit(hit), .point_x(point_x), .point_y(point_y)
	);

	always #2 clk = ~clk;

	function automatic logic signed [W-1:0] lerp_axis(logic signed [W-1:0] start,
			logic signed [W:0] delta, logic signed [2*W+3:0] num,
			logic signed [2*W+3:0] den);
		logic [3*W+8:0] prod;
		logic [3*W+8:0] q;
		logic [W:0] mag;
		mag = delta[W] ? -delta : delta;
		prod = num * mag;
		q = prod / den;
		if (delta[W])
			q = -q;
		return start + q[W-1:0];
	endfunction

	function automatic crossing_t predict_crossing(seg_pair_t s);
		crossing_t r;
		logic signed [2*W+3:0] dax, day, dbx, dby, ex, ey, d, nu, nv;
		dax = s.ax1 - s.ax0;
		day = s.ay1 - s.ay0;
		dbx = s.bx1 - s.bx0;
		dby = s.by1 - s.by0;
		ex = s.bx0 - s.ax0;
		ey = s.by0 - s.ay0;
		d = dax * dby - day * dbx;
		nu = ex * dby - ey * dbx;
		nv = ex * day - ey * dax;
		r = '{1'b0, '0, '0};
		if (d == 0)
			return r;
		if (d < 0) begin
			d = -d;
			nu = -nu;
			nv = -nv;
		end
		if (nu < 0 || nu > d || nv < 0 || nv > d)
			return r;
		r.hit = 1'b1;
		r.px = lerp_axis(s.ax0, dax[W:0], nu, d);
		r.py = lerp_axis(s.ay0, day[W:0], nu, d);
		return r;
	endfunction

	function automatic logic signed [W-1:0] rand_coord(int mode);
		case (mode)
			0: return W'($urandom);
			1: return W'($signed($urandom_range(0, 2000)) - 1000);
			2: return $urandom_range(0, 1) ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
			default: return W'(($signed($urandom_range(0, 200)) - 100) <<< 16);
		endcase
	endfunction

	function automatic seg_pair_t make_pair(logic signed [W-1:0] ax0, ay0, ax1, ay1,
			bx0, by0, bx1, by1);
		seg_pair_t s;
		s = '{ax0, ay0, ax1, ay1, bx0, by0, bx1, by1};
		return s;
	endfunction

	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
	endfunction

	initial begin
		seg_pair_t s;
		logic signed [W-1:0] mx, mn, one;
		int mode;
		mx = {1'b0, {(W-1){1'b1}}};
		mn = {1'b1, {(W-1){1'b0}}};
		one = 32'sh10000;
		pending_pairs.push_back(make_pair(0, 0, 4*one, 4*one, 0, 4*one, 4*one, 0));
		pending_pairs.push_back(make_pair(0, 0, 4*one, 0, 0, one, 4*one, one));
		pending_pairs.push_back(make_pair(0, 0, 4*one, 0, one, 0, 3*one, 0));
		pending_pairs.push_back(make_pair(one, one, one, one, 0, 0, 2*one, 2*one));
		pending_pairs.push_back(make_pair(0, 0, 2*one, 0, 2*one, -one, 2*one, one));
		pending_pairs.push_back(make_pair(0, 0, 2*one, 0, 0, 0, 0, one));
		pending_pairs.push_back(make_pair(0, 0, 2*one, 0, 3*one, -one, 3*one, one));
		pending_pairs.push_back(make_pair(0, 0, 2*one, 0, one, one, one, 3*one));
		pending_pairs.push_back(make_pair(mn, mn, mx, mx, mn, mx, mx, mn));
		pending_pairs.push_back(make_pair(mx, mn, mn, mx, mn, mn, mx, mx));
		pending_pairs.push_back(make_pair(mn, 0, mx, 0, 0, mn, 0, mx));
		pending_pairs.push_back(make_pair(mx, mx, mn, mn, mx, mn, mn, mx));
		pending_pairs.push_back(make_pair(-1, -1, 1, 1, -1, 1, 1, -1));
		pending_pairs.push_back(make_pair(0, 0, 3, 0, 1, -1, 2, 2));
		pending_pairs.push_back(make_pair(mn, mn, mn, mn, mn, mn, mn, mn));
		pending_pairs.push_back(make_pair(mx, mx, mx, mx, mx, mx, mx, mx));
		for (int i = 0; i < N_RANDOM; i++) begin
			mode = $urandom_range(0, 3);
			if ($urandom_range(0, 2) != 0) begin
				// build a pair around a random point; modes 0 and 2 use a fully random pair instead
				logic signed [W-1:0] cx, cy;
				cx = rand_coord(mode);
				cy = rand_coord(mode);
				s = make_pair(cx - rand_coord(1), cy - rand_coord(1),
					cx + rand_coord(1), cy + rand_coord(1),
					cx - rand_coord(1), cy + rand_coord(1),
					cx + rand_coord(1), cy - rand_coord(1));
				if (mode == 0 || mode == 2)
					s = make_pair(rand_coord(mode), rand_coord(mode), rand_coord(mode),
						rand_coord(mode), rand_coord(mode), rand_coord(mode),
						rand_coord(mode), rand_coord(mode));
			end else
				s = make_pair(rand_coord(mode), rand_coord(mode), rand_coord(mode),
					rand_coord(mode), rand_coord(mode), rand_coord(mode),
					rand_coord(mode), rand_coord(mode));
			pending_pairs.push_back(s);
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	int drive_gap = 0;
	logic accepted_q;
	always @(posedge clk) begin
		accepted_q <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall)
			expected_crossings.push_back(predict_crossing(make_pair(a_start_x, a_start_y,
				a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y)));
	end

	always @(negedge clk) begin
		seg_pair_t s;
		if (arst_n && (!in_valid || accepted_q)) begin
			if (in_valid && drive_gap == 0 && pending_pairs.size() != 0) begin
				s = pending_pairs.pop_front();
				{a_start_x, a_start_y, a_end_x, a_end_y} = {s.ax0, s.ay0, s.ax1, s.ay1};
				{b_start_x, b_start_y, b_end_x, b_end_y} = {s.bx0, s.by0, s.bx1, s.by1};
				drive_gap = gap_len();
				if ($urandom_range(0, 3) != 0)
					drive_gap = 0;
			end else if (drive_gap > 0) begin
				in_valid = 1'b0;
				drive_gap--;
			end else if (pending_pairs.size() != 0) begin
				s = pending_pairs.pop_front();
				{a_start_x, a_start_y, a_end_x, a_end_y} = {s.ax0, s.ay0, s.ax1, s.ay1};
				{b_start_x, b_start_y, b_end_x, b_end_y} = {s.bx0, s.by0, s.bx1, s.by1};
				in_valid = 1'b1;
				drive_gap = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
			end else begin
				in_valid = 1'b0;
				stimulus_done = 1'b1;
			end
		end
	end

	int stall_left = 0;
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall = 1'b1;
			stall_left--;
		end else if ($urandom_range(0, 5) == 0) begin
			out_stall = 1'b1;
			stall_left = gap_len();
		end else
			out_stall = 1'b0;
	end

	always @(posedge clk) begin
		crossing_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_crossings.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transaction: hit=%0b x=%0d y=%0d", hit, point_x, point_y);
			end else begin
				e = expected_crossings.pop_front();
				if (hit !== e.hit || point_x !== e.px || point_y !== e.py) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected hit=%0b x=%0d y=%0d, got hit=%0b x=%0d y=%0d",
							e.hit, e.px, e.py, hit, point_x, point_y);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("segment_intersection_top_tb failed");
			$finish;
		end
	end

	initial begin
		wait (stimulus_done);
		wait (expected_crossings.size() == 0);
		repeat (2 * LATENCY) @(posedge clk);
		if (mismatches == 0 && expected_crossings.size() == 0)
			$display("segment_intersection_top_tb passed");
		else
			$display("segment_intersection_top_tb failed");
		$finish;
	end

endmodule
